@@ rtl/tss_pkg.sv @@
// Shared types and constants for the triangle strip stitcher.
// Depends on nothing; imported by every module of the block.
package tss_pkg;

  localparam int unsigned VW = 32;

  // Output sequence of one join: 18-word bridge, then n1, n2.
  localparam int unsigned SEQ_LEN = 20;
  localparam int unsigned STEP_W  = $clog2(SEQ_LEN);

  localparam logic [STEP_W-1:0] STEP_BRIDGE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_PAIR   = STEP_W'(SEQ_LEN - 2);
  localparam logic [STEP_W-1:0] STEP_SINGLE = STEP_W'(SEQ_LEN - 1);
  localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(SEQ_LEN - 1);

  // Job queue depth between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Strip position codes.
  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_HELD  = 2'd1;
  localparam logic [1:0] POS_EMIT  = 2'd2;

  // Word source codes.
  localparam logic [1:0] SRC_P2 = 2'd0;
  localparam logic [1:0] SRC_P1 = 2'd1;
  localparam logic [1:0] SRC_N1 = 2'd2;
  localparam logic [1:0] SRC_N2 = 2'd3;

  typedef struct packed {
    logic [STEP_W-1:0] first_step;
    logic [VW-1:0]     p1;
    logic [VW-1:0]     p2;
    logic [VW-1:0]     n1;
    logic [VW-1:0]     n2;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } qwr_t;

  typedef struct packed {
    logic avail;
    job_t job;
  } qrd_t;

  // Source of each word in the join sequence.
  function automatic logic [1:0] seq_src(input logic [STEP_W-1:0] step);
    logic [1:0] src;
    unique case (step)
      5'd0:    src = SRC_P2;
      5'd1:    src = SRC_P1;
      5'd2:    src = SRC_P1;
      5'd3:    src = SRC_P1;
      5'd4:    src = SRC_P1;
      5'd5:    src = SRC_N1;
      5'd6:    src = SRC_P1;
      5'd7:    src = SRC_N1;
      5'd8:    src = SRC_N1;
      5'd9:    src = SRC_N1;
      5'd10:   src = SRC_N1;
      5'd11:   src = SRC_N2;
      5'd12:   src = SRC_N1;
      5'd13:   src = SRC_N2;
      5'd14:   src = SRC_N1;
      5'd15:   src = SRC_N1;
      5'd16:   src = SRC_N1;
      5'd17:   src = SRC_N2;
      5'd18:   src = SRC_N1;
      default: src = SRC_N2;
    endcase
    return src;
  endfunction

endpackage

@@ rtl/triangle_strip_stitcher.sv @@
// Channel  | Direction | Handshake          | Word
// in_      | input     | in_valid/in_stall  | vertex_index, strip_end, empty_strip, batch_start
// out_     | output    | out_valid/out_stall| vertex_out, run_last
//
// One input word is taken per cycle while the four-entry job queue has room.
// The back sequencer emits one output word per cycle while out_ is not stalled: a strip join
// emits the bridge plus n1, n2, a first join without bridge only n1, n2, a later vertex itself.
// Each job goes through the queue and the current-job register into the output register.
// Reset (rst_n low, synchronous) clears strip history, queue and output.
// A stall on out_ holds the output register; the queue absorbs input until full.
//
// Depends on tss_pkg, tss_front, tss_queue and tss_back.
module triangle_strip_stitcher
  import tss_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [VW-1:0] in_vertex_index,
  input  logic          in_strip_end,
  input  logic          in_empty_strip,
  input  logic          in_batch_start,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [VW-1:0] out_vertex_out,
  output logic          out_run_last
);

  qwr_t qwr;
  qrd_t qrd;
  logic q_full;
  logic q_pop;

  // Front: classify the word against strip history, push a job when it emits.
  tss_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_vertex_index (in_vertex_index),
    .in_strip_end    (in_strip_end),
    .in_empty_strip  (in_empty_strip),
    .in_batch_start  (in_batch_start),
    .q_full          (q_full),
    .in_stall        (in_stall),
    .qwr             (qwr)
  );

  // Queue: decouple the front from bridge bursts in the back.
  tss_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qwr   (qwr),
    .pop   (q_pop),
    .full  (q_full),
    .qrd   (qrd)
  );

  // Back: walk each job's sequence, one word per cycle while out_ is not stalled, into the output register.
  tss_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qrd            (qrd),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_vertex_out (out_vertex_out),
    .out_run_last   (out_run_last)
  );

endmodule

@@ rtl/tss_front.sv @@
// Front end: accepts input words, tracks strip history, issues emit jobs.
// Depends on tss_pkg.
module tss_front
  import tss_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [VW-1:0] in_vertex_index,
  input  logic          in_strip_end,
  input  logic          in_empty_strip,
  input  logic          in_batch_start,
  input  logic          q_full,
  output logic          in_stall,
  output qwr_t          qwr
);

  logic [VW-1:0] held_first_r, held_first_nxt;
  logic [VW-1:0] tail_last_r, tail_last_nxt;
  logic [VW-1:0] tail_sl_r, tail_sl_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic          prev_ok_r, prev_ok_nxt;
  logic          accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    // Batch start clears history before the word is handled.
    held_first_nxt = in_batch_start ? '0 : held_first_r;
    tail_last_nxt  = in_batch_start ? '0 : tail_last_r;
    tail_sl_nxt    = in_batch_start ? '0 : tail_sl_r;
    pos_nxt        = in_batch_start ? POS_START : pos_r;
    prev_ok_nxt    = in_batch_start ? 1'b0 : prev_ok_r;

    qwr.push           = 1'b0;
    qwr.job.first_step = STEP_SINGLE;
    qwr.job.p1         = tail_last_nxt;
    qwr.job.p2         = tail_sl_nxt;
    qwr.job.n1         = held_first_nxt;
    qwr.job.n2         = in_vertex_index;

    priority if (in_empty_strip) begin
      pos_nxt     = POS_START;
      prev_ok_nxt = 1'b0;
    end else if (pos_nxt == POS_START) begin
      if (in_strip_end) begin
        prev_ok_nxt = 1'b0;
      end else begin
        held_first_nxt = in_vertex_index;
        pos_nxt        = POS_HELD;
      end
    end else begin
      qwr.push = accept;
      if (pos_nxt == POS_HELD) begin
        qwr.job.first_step = prev_ok_nxt ? STEP_BRIDGE : STEP_PAIR;
        tail_sl_nxt        = held_first_nxt;
      end else begin
        tail_sl_nxt = tail_last_nxt;
      end
      tail_last_nxt = in_vertex_index;
      pos_nxt       = POS_EMIT;
      if (in_strip_end) begin
        prev_ok_nxt = 1'b1;
        pos_nxt     = POS_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_START;
      prev_ok_r    <= 1'b0;
      held_first_r <= '0;
      tail_last_r  <= '0;
      tail_sl_r    <= '0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      prev_ok_r    <= prev_ok_nxt;
      held_first_r <= held_first_nxt;
      tail_last_r  <= tail_last_nxt;
      tail_sl_r    <= tail_sl_nxt;
    end
  end

endmodule

@@ rtl/tss_queue.sv @@
// Short job queue between front and back end.
// Depends on tss_pkg.
module tss_queue
  import tss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  qwr_t qwr,
  input  logic pop,
  output logic full,
  output qrd_t qrd
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign qrd.avail = (cnt_r != '0);
  assign qrd.job   = mem_r[rd_ptr_r];
  assign do_push   = qwr.push && !full;
  assign do_pop    = pop && qrd.avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= qwr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

@@ rtl/tss_back.sv @@
// Back end: steps through each job's word sequence into an output register.
// Depends on tss_pkg.
module tss_back
  import tss_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  qrd_t          qrd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [VW-1:0] out_vertex_out,
  output logic          out_run_last
);

  job_t              cur_job_r;
  logic              cur_valid_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [VW-1:0]     out_vertex_r;
  logic              out_last_r;
  logic              out_free, emit, emit_last;
  logic [VW-1:0]     word;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = cur_valid_r && out_free;
  assign emit_last = emit && (step_r == STEP_LAST);
  assign pop       = qrd.avail && (!cur_valid_r || emit_last);

  always_comb begin
    unique case (seq_src(step_r))
      SRC_P2:  word = cur_job_r.p2;
      SRC_P1:  word = cur_job_r.p1;
      SRC_N1:  word = cur_job_r.n1;
      default: word = cur_job_r.n2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_job_r <= qrd.job;
    end
    if (emit) begin
      out_vertex_r <= word;
      out_last_r   <= (step_r == STEP_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        step_r      <= qrd.job.first_step;
      end else if (emit_last) begin
        cur_valid_r <= 1'b0;
      end else if (emit) begin
        step_r <= step_r + 1'b1;
      end
      if (out_free) begin
        out_valid_r <= cur_valid_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_out = out_vertex_r;
  assign out_run_last   = out_last_r;

endmodule

@@ rtl/tss_checker.sv @@
// Port-level checks for the triangle strip stitcher, bound to the top level.
// Depends on tss_pkg and triangle_strip_stitcher.
module tss_checker
  import tss_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic [VW-1:0] out_vertex_out,
  input logic          out_run_last
);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_vertex_out) && $stable(out_run_last))
    else $error("stalled output word changed");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset empties the job queue, so input is open right after.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind triangle_strip_stitcher tss_checker u_tss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_vertex_out (out_vertex_out),
  .out_run_last   (out_run_last)
);
